### rtl/cascaded_biquad_equalizer_macros.svh
`ifndef CASCADED_BIQUAD_EQUALIZER_MACROS_SVH
`define CASCADED_BIQUAD_EQUALIZER_MACROS_SVH

// clocked assertion, quiet while reset is asserted
`define CBQ_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// antecedent in one cycle, consequent in the next
`define CBQ_ASSERT_NEXT(label, ante, cons, msg) \
	`CBQ_ASSERT(label, (ante) |=> (cons), msg)

`endif

### rtl/cbq_pkg.sv
package cbq_pkg;

	localparam int BANDS_DEF  = 8;
	localparam int NCOEF      = 5;
	localparam int NHIST      = 4;
	localparam int SAMP_W     = 24;
	localparam int COEF_W     = 32;
	localparam int PROD_W     = SAMP_W + COEF_W;
	localparam int ACC_W      = 60;
	localparam int FRAC_SHIFT = 26;
	localparam int LD_AW      = 7;
	localparam int PH_W       = 3;

	localparam logic [PH_W-1:0] PH_LAST = PH_W'(NCOEF + 1);

	// coefficient slots within a section
	localparam logic [2:0] K_B0 = 3'd0;
	localparam logic [2:0] K_B1 = 3'd1;
	localparam logic [2:0] K_B2 = 3'd2;
	localparam logic [2:0] K_A1 = 3'd3;
	localparam logic [2:0] K_A2 = 3'd4;

	localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (FRAC_SHIFT - 1);
	localparam logic signed [SAMP_W-1:0] SAT_MAX = {1'b0, {(SAMP_W-1){1'b1}}};
	localparam logic signed [SAMP_W-1:0] SAT_MIN = {1'b1, {(SAMP_W-1){1'b0}}};

	typedef enum logic [1:0] {
		OP_PROC  = 2'd0,
		OP_LOAD  = 2'd1,
		OP_CLEAR = 2'd2
	} opcode_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic en;
		logic first;
		logic sub;
	} mac_ctl_t;

endpackage

### rtl/cbq_mac.sv
module cbq_mac (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  cbq_pkg::mac_ctl_t                     ctl,
	input  logic signed [cbq_pkg::COEF_W-1:0]     coef,
	input  logic signed [cbq_pkg::SAMP_W-1:0]     operand,
	output logic signed [cbq_pkg::SAMP_W-1:0]     y,
	output logic                                  sat
);
	import cbq_pkg::*;

	localparam int HI_LSB = FRAC_SHIFT + SAMP_W - 1;

	mac_ctl_t                   ctl_s2;
	logic signed [PROD_W-1:0]   prod_s2;
	logic signed [ACC_W-1:0]    acc_q;
	logic signed [ACC_W-1:0]    prod_ext;
	logic signed [ACC_W-1:0]    acc_base;
	logic [ACC_W-1:HI_LSB]      acc_hi;
	logic                       in_range;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2 <= '0;
		end else begin
			ctl_s2 <= ctl;
		end
	end

	always_ff @(posedge clk) begin
		prod_s2 <= PROD_W'(coef) * PROD_W'(operand);
	end

	assign prod_ext = ACC_W'(prod_s2);
	assign acc_base = ctl_s2.first ? $signed(ROUND_BIAS) : acc_q;

	// bias is folded in at the first product so the final shift rounds half up
	always_ff @(posedge clk) begin
		if (ctl_s2.en) begin
			acc_q <= ctl_s2.sub ? (acc_base - prod_ext) : (acc_base + prod_ext);
		end
	end

	assign acc_hi   = acc_q[ACC_W-1:HI_LSB];
	assign in_range = (&acc_hi) | ~(|acc_hi);
	assign sat      = ~in_range;
	assign y        = in_range ? acc_q[HI_LSB:FRAC_SHIFT]
	                           : (acc_q[ACC_W-1] ? SAT_MIN : SAT_MAX);

endmodule

### rtl/cascaded_biquad_equalizer.sv
// a process item runs the sections in order and its result is registered at the end
// a new item is taken only once the block is idle again: the shared multiplier does
//   five products per section plus a two-stage drain, then a result state returns to idle;
//   longer only while an earlier result waits; load and clear items keep the block ready
// reset: coefficients and filter history read as zero, no result pending, block ready
// a clear item zeroes all history at once through per-row valid bits
module cascaded_biquad_equalizer #(
	parameter int BANDS = cbq_pkg::BANDS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic [1:0]                            opcode,
	input  logic signed [cbq_pkg::SAMP_W-1:0]     sample_in,
	input  logic                                  block_last,
	input  logic [2:0]                            band_select,
	input  logic [2:0]                            coef_select,
	input  logic signed [cbq_pkg::COEF_W-1:0]     coef_value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [cbq_pkg::SAMP_W-1:0]     sample_out,
	output logic                                  clipped,
	output logic                                  block_last_out
);
	import cbq_pkg::*;

	localparam int NCW     = BANDS * NCOEF;
	localparam int CAW     = $clog2(NCW);
	localparam int BW      = (BANDS > 1) ? $clog2(BANDS) : 1;
	localparam int ROW_W   = NHIST * SAMP_W;

	// sequencer
	state_t               state_q, state_d;
	logic [BW-1:0]        band_q;
	logic [PH_W-1:0]      ph_q;
	logic [CAW-1:0]       caddr_q;

	// per-item working registers
	logic signed [SAMP_W-1:0] x_q;
	logic                     blast_q;
	logic                     clip_q;

	// coefficient store: one word per entry, valid bit per entry
	logic signed [COEF_W-1:0] coef_mem [NCW];
	logic [NCW-1:0]           coef_vld_q;
	logic signed [COEF_W-1:0] coef_rd_s1;
	logic                     coef_ok_s1;

	// history store: one row per section, {y2, y1, x2, x1}
	logic [ROW_W-1:0]         hist_mem [BANDS];
	logic [BANDS-1:0]         hist_vld_q;
	logic [ROW_W-1:0]         hist_rd_q;
	logic                     hist_ok_q;

	// multiplier stage one
	mac_ctl_t                 ctl_s1;
	logic [2:0]               k_s1;

	// output register
	logic                     out_valid_q;
	logic signed [SAMP_W-1:0] sample_out_q;
	logic                     clipped_q;
	logic                     block_last_out_q;

	// handshake and sequencing strobes
	logic                     in_acc;
	logic                     start;
	logic                     ld_we;
	logic                     clr;
	logic                     issue;
	logic                     hist_rd_en;
	logic                     round_mid;
	logic                     finish_go;
	logic                     wb;
	logic                     last_band;
	logic [BW-1:0]            wb_row;
	logic [LD_AW-1:0]         ld_addr7;
	logic [CAW-1:0]           ld_addr;

	// datapath
	logic [ROW_W-1:0]         hist_row;
	logic signed [SAMP_W-1:0] h_x1, h_x2, h_y1, h_y2;
	logic signed [SAMP_W-1:0] mac_operand;
	logic signed [COEF_W-1:0] mac_coef;
	logic signed [SAMP_W-1:0] y;
	logic                     sat;
	logic [ROW_W-1:0]         new_row;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_acc    = in_valid & in_ready;
	assign last_band = (band_q == BW'(BANDS - 1));

	// load address is band*5 + slot; writes outside the configured bands are dropped
	assign ld_addr7 = {2'b00, band_select, 2'b00} + LD_AW'(band_select) + LD_AW'(coef_select);
	assign ld_addr  = ld_addr7[CAW-1:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_acc && opcode == OP_PROC) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (ph_q == PH_LAST && last_band) state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		start      = 1'b0;
		ld_we      = 1'b0;
		clr        = 1'b0;
		issue      = 1'b0;
		hist_rd_en = 1'b0;
		round_mid  = 1'b0;
		finish_go  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				start = in_acc && opcode == OP_PROC;
				ld_we = in_acc && opcode == OP_LOAD
				        && (5'(band_select) < 5'(BANDS)) && (coef_select <= K_A2);
				clr   = in_acc && opcode == OP_CLEAR;
			end
			ST_RUN: begin
				// each section runs phases 0..6: reads issue in 0..4, products drain in 5..6
				issue      = (ph_q < PH_W'(NCOEF));
				hist_rd_en = (ph_q == '0);
				// previous section finishes while this one starts its reads
				round_mid  = (ph_q == '0) && (band_q != '0);
			end
			ST_FINISH: begin
				finish_go = !out_valid_q || out_ready;
			end
			default: begin
			end
		endcase
	end

	assign wb     = round_mid | finish_go;
	assign wb_row = round_mid ? (band_q - BW'(1)) : band_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			band_q  <= '0;
			ph_q    <= '0;
			caddr_q <= '0;
		end else begin
			state_q <= state_d;
			if (start) begin
				band_q  <= '0;
				ph_q    <= '0;
				caddr_q <= '0;
			end else if (state_q == ST_RUN) begin
				if (ph_q == PH_LAST) begin
					ph_q <= '0;
					if (!last_band) band_q <= band_q + BW'(1);
				end else begin
					ph_q <= ph_q + PH_W'(1);
				end
				if (issue) caddr_q <= caddr_q + CAW'(1);
			end
		end
	end

	// coefficient memory
	always_ff @(posedge clk) begin
		if (ld_we) coef_mem[ld_addr] <= coef_value;
	end

	always_ff @(posedge clk) begin
		if (issue) coef_rd_s1 <= coef_mem[caddr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_vld_q <= '0;
			coef_ok_s1 <= 1'b0;
		end else begin
			if (ld_we) coef_vld_q[ld_addr] <= 1'b1;
			if (issue) coef_ok_s1 <= coef_vld_q[caddr_q];
		end
	end

	// history memory
	always_ff @(posedge clk) begin
		if (wb) hist_mem[wb_row] <= new_row;
	end

	always_ff @(posedge clk) begin
		if (hist_rd_en) hist_rd_q <= hist_mem[band_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hist_vld_q <= '0;
			hist_ok_q  <= 1'b0;
		end else begin
			if (clr) hist_vld_q <= '0;
			else if (wb) hist_vld_q[wb_row] <= 1'b1;
			if (hist_rd_en) hist_ok_q <= hist_vld_q[band_q];
		end
	end

	// rows never written since reset or clear read as zero
	assign hist_row = hist_ok_q ? hist_rd_q : '0;
	assign h_x1     = hist_row[1*SAMP_W-1:0*SAMP_W];
	assign h_x2     = hist_row[2*SAMP_W-1:1*SAMP_W];
	assign h_y1     = hist_row[3*SAMP_W-1:2*SAMP_W];
	assign h_y2     = hist_row[4*SAMP_W-1:3*SAMP_W];

	// shift the section's history: x1 takes its input, y1 its output
	assign new_row  = {h_y1, y, h_x1, x_q};

	// tag of the operand pair arriving from the memories
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1.en    <= issue;
			ctl_s1.first <= (ph_q == K_B0);
			ctl_s1.sub   <= (ph_q == K_A1) || (ph_q == K_A2);
		end
	end

	always_ff @(posedge clk) begin
		k_s1 <= ph_q;
	end

	always_comb begin
		case (k_s1)
			K_B0:    mac_operand = x_q;
			K_B1:    mac_operand = h_x1;
			K_B2:    mac_operand = h_x2;
			K_A1:    mac_operand = h_y1;
			K_A2:    mac_operand = h_y2;
			default: mac_operand = '0;
		endcase
	end

	assign mac_coef = coef_ok_s1 ? coef_rd_s1 : '0;

	cbq_mac u_mac (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (ctl_s1),
		.coef    (mac_coef),
		.operand (mac_operand),
		.y       (y),
		.sat     (sat)
	);

	// section input and saturation flag carried across the cascade
	always_ff @(posedge clk) begin
		if (start) begin
			x_q     <= sample_in;
			blast_q <= block_last;
		end else if (round_mid) begin
			x_q <= y;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q <= 1'b0;
		end else if (start) begin
			clip_q <= 1'b0;
		end else if (round_mid) begin
			clip_q <= clip_q | sat;
		end
	end

	// result register; the last section's rounding lands here directly
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (finish_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (finish_go) begin
			sample_out_q     <= y;
			clipped_q        <= clip_q | sat;
			block_last_out_q <= blast_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign sample_out     = sample_out_q;
	assign clipped        = clipped_q;
	assign block_last_out = block_last_out_q;

endmodule

### rtl/cbq_checker.sv
`include "cascaded_biquad_equalizer_macros.svh"

module cbq_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_valid,
	input logic                                  in_ready,
	input logic [1:0]                            opcode,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [cbq_pkg::SAMP_W-1:0]     sample_out,
	input logic                                  clipped,
	input logic                                  block_last_out
);
	import cbq_pkg::*;

	// a stalled result holds
	`CBQ_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(sample_out) && $stable(clipped) && $stable(block_last_out), "result changed while stalled")

	// a process item occupies the block
	`CBQ_ASSERT_NEXT(a_proc_busy, in_valid && in_ready && opcode == OP_PROC, !in_ready, "ready after process item")

	// load, clear and unused items leave the block ready
	`CBQ_ASSERT_NEXT(a_cmd_quick, in_valid && in_ready && opcode != OP_PROC, in_ready, "command item stalled block")

	// a new result only comes out of a running item
	`CBQ_ASSERT(a_result_src, $rose(out_valid) |-> !$past(in_ready), "result without work")

endmodule

bind cascaded_biquad_equalizer cbq_checker u_cbq_checker (.*);
